/* hw/rtl/cfs_pkg.sv */
// Shared types, widths and face codes for the cube-map face selector.
// Used by cfs_select, cfs_div_cell and cube_map_face_select; no dependencies.
package cfs_pkg;

    localparam int COORD_BITS = 16;
    localparam int UV_BITS    = 16;
    // Numerator c + m and denominator 2m both lie in [0, 2^COORD_BITS].
    localparam int NUM_W      = COORD_BITS + 1;

    localparam logic [2:0] FACE_FRONT  = 3'd0;
    localparam logic [2:0] FACE_BACK   = 3'd1;
    localparam logic [2:0] FACE_LEFT   = 3'd2;
    localparam logic [2:0] FACE_RIGHT  = 3'd3;
    localparam logic [2:0] FACE_TOP    = 3'd4;
    localparam logic [2:0] FACE_BOTTOM = 3'd5;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] dir_x;
        logic signed [COORD_BITS-1:0] dir_y;
        logic signed [COORD_BITS-1:0] dir_z;
    } cfs_in_t;

    typedef struct packed {
        logic [2:0]         face;
        logic [UV_BITS-1:0] tex_u;
        logic [UV_BITS-1:0] tex_v;
        logic               zero_direction;
    } cfs_out_t;

    // Major axis picked, coordinate sources swapped and signed per face.
    typedef struct packed {
        logic [2:0]                face;
        logic                      zero;
        logic [COORD_BITS-1:0]     mag;
        logic signed [COORD_BITS:0] cu;
        logic signed [COORD_BITS:0] cv;
    } cfs_sel_t;

    // State handed from one divider cell to the next.
    typedef struct packed {
        logic [2:0]         face;
        logic               zero;
        logic               sat_u;
        logic               sat_v;
        logic [NUM_W-1:0]   den;
        logic [NUM_W-1:0]   rem_u;
        logic [NUM_W-1:0]   rem_v;
        logic [UV_BITS-1:0] quo_u;
        logic [UV_BITS-1:0] quo_v;
    } cfs_div_t;

endpackage

/* hw/rtl/cfs_select.sv */
// Major-axis select and divider setup, two register stages.
// Depends on cfs_pkg.
module cfs_select (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en_a,
    input  logic              en_b,
    input  logic              src_valid,
    input  cfs_pkg::cfs_in_t  src,
    output logic              sel_valid,
    output logic              dst_valid,
    output cfs_pkg::cfs_div_t dst
);
    import cfs_pkg::*;

    logic                       sel_valid_reg;
    cfs_sel_t                   sel_reg;
    cfs_sel_t                   sel_next;
    logic                       dst_valid_reg;
    cfs_div_t                   dst_reg;
    cfs_div_t                   dst_next;

    logic [COORD_BITS-1:0]      ax;
    logic [COORD_BITS-1:0]      ay;
    logic [COORD_BITS-1:0]      az;
    logic signed [COORD_BITS:0] xe;
    logic signed [COORD_BITS:0] ye;
    logic signed [COORD_BITS:0] ze;
    logic                       pick_x;
    logic                       pick_y;
    logic signed [COORD_BITS+1:0] sum_u;
    logic signed [COORD_BITS+1:0] sum_v;
    logic signed [COORD_BITS+1:0] mag_ext;

    // Stage a: magnitudes, tie-break x over y over z, face and sources.
    always_comb
    begin
        xe     = {src.dir_x[COORD_BITS-1], src.dir_x};
        ye     = {src.dir_y[COORD_BITS-1], src.dir_y};
        ze     = {src.dir_z[COORD_BITS-1], src.dir_z};
        ax     = src.dir_x[COORD_BITS-1] ? COORD_BITS'(-xe) : COORD_BITS'(xe);
        ay     = src.dir_y[COORD_BITS-1] ? COORD_BITS'(-ye) : COORD_BITS'(ye);
        az     = src.dir_z[COORD_BITS-1] ? COORD_BITS'(-ze) : COORD_BITS'(ze);
        pick_x = (ax >= ay) && (ax >= az);
        pick_y = (ay >= az);

        sel_next.zero = (ax == '0) && (ay == '0) && (az == '0);
        priority if (sel_next.zero)
        begin
            sel_next.face = FACE_FRONT;
            sel_next.mag  = '0;
            sel_next.cu   = '0;
            sel_next.cv   = '0;
        end
        else if (pick_x)
        begin
            sel_next.mag  = ax;
            sel_next.cv   = ye;
            sel_next.face = src.dir_x[COORD_BITS-1] ? FACE_LEFT : FACE_RIGHT;
            sel_next.cu   = src.dir_x[COORD_BITS-1] ? ze : -ze;
        end
        else if (pick_y)
        begin
            sel_next.mag  = ay;
            sel_next.cu   = xe;
            sel_next.face = src.dir_y[COORD_BITS-1] ? FACE_BOTTOM : FACE_TOP;
            sel_next.cv   = src.dir_y[COORD_BITS-1] ? ze : -ze;
        end
        else
        begin
            sel_next.mag  = az;
            sel_next.cv   = ye;
            sel_next.face = src.dir_z[COORD_BITS-1] ? FACE_BACK : FACE_FRONT;
            sel_next.cu   = src.dir_z[COORD_BITS-1] ? -xe : xe;
        end
    end

    // Stage b: numerator c + m, denominator 2m, exact-one detect.
    always_comb
    begin
        mag_ext        = signed'({2'b00, sel_reg.mag});
        sum_u          = {sel_reg.cu[COORD_BITS], sel_reg.cu} + mag_ext;
        sum_v          = {sel_reg.cv[COORD_BITS], sel_reg.cv} + mag_ext;
        dst_next.face  = sel_reg.face;
        dst_next.zero  = sel_reg.zero;
        dst_next.sat_u = ({sel_reg.cu[COORD_BITS], sel_reg.cu} == mag_ext);
        dst_next.sat_v = ({sel_reg.cv[COORD_BITS], sel_reg.cv} == mag_ext);
        dst_next.den   = {sel_reg.mag, 1'b0};
        dst_next.rem_u = sum_u[NUM_W-1:0];
        dst_next.rem_v = sum_v[NUM_W-1:0];
        dst_next.quo_u = '0;
        dst_next.quo_v = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_valid_reg <= 1'b0;
            dst_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
            begin
                sel_valid_reg <= src_valid;
            end
            if (en_b)
            begin
                dst_valid_reg <= sel_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a && src_valid)
        begin
            sel_reg <= sel_next;
        end
        if (en_b && sel_valid_reg)
        begin
            dst_reg <= dst_next;
        end
    end

    assign sel_valid = sel_valid_reg;
    assign dst_valid = dst_valid_reg;
    assign dst       = dst_reg;

endmodule

/* hw/rtl/cfs_div_cell.sv */
// One restoring-division cell: one quotient bit for u and for v per stage.
// Depends on cfs_pkg.
module cfs_div_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              src_valid,
    input  cfs_pkg::cfs_div_t src,
    output logic              dst_valid,
    output cfs_pkg::cfs_div_t dst
);
    import cfs_pkg::*;

    logic             dst_valid_reg;
    cfs_div_t         dst_reg;
    cfs_div_t         dst_next;
    logic [NUM_W:0]   dbl_u;
    logic [NUM_W:0]   dbl_v;
    logic [NUM_W:0]   den_ext;
    logic             ge_u;
    logic             ge_v;
    logic [NUM_W:0]   dif_u;
    logic [NUM_W:0]   dif_v;

    always_comb
    begin
        den_ext  = {1'b0, src.den};
        dbl_u    = {src.rem_u, 1'b0};
        dbl_v    = {src.rem_v, 1'b0};
        ge_u     = (dbl_u >= den_ext);
        ge_v     = (dbl_v >= den_ext);
        dif_u    = dbl_u - den_ext;
        dif_v    = dbl_v - den_ext;
        dst_next = src;
        // Remainder never exceeds the divisor, so it fits back in NUM_W bits.
        dst_next.rem_u = ge_u ? dif_u[NUM_W-1:0] : dbl_u[NUM_W-1:0];
        dst_next.rem_v = ge_v ? dif_v[NUM_W-1:0] : dbl_v[NUM_W-1:0];
        dst_next.quo_u = {src.quo_u[UV_BITS-2:0], ge_u};
        dst_next.quo_v = {src.quo_v[UV_BITS-2:0], ge_v};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dst_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            dst_valid_reg <= src_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && src_valid)
        begin
            dst_reg <= dst_next;
        end
    end

    assign dst_valid = dst_valid_reg;
    assign dst       = dst_reg;

endmodule

/* hw/rtl/cube_map_face_select.sv */
// Cube-map face selector. Throughput one beat per cycle unless the output stalls
// with res_ready low; the 16-cell divider chain yields one quotient bit per cell.
// Every stage holds its own valid bit and fills any bubble while the output waits.
// Reset clears the valid bits only; no clearing pass.
// Depends on cfs_pkg, cfs_select and cfs_div_cell.
module cube_map_face_select (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              dir_valid,
    output logic              dir_ready,
    input  cfs_pkg::cfs_in_t  dir,
    output logic              res_valid,
    input  logic              res_ready,
    output cfs_pkg::cfs_out_t res
);
    import cfs_pkg::*;

    logic               sel_valid;
    logic               en_a;
    logic               en_b;
    logic [UV_BITS:0]   div_valid;
    cfs_div_t           div_data [0:UV_BITS];
    logic [UV_BITS-1:0] cell_en;
    cfs_div_t           last;

    cfs_select u_select (
        .clk       (clk),
        .rst_n     (rst_n),
        .en_a      (en_a),
        .en_b      (en_b),
        .src_valid (dir_valid),
        .src       (dir),
        .sel_valid (sel_valid),
        .dst_valid (div_valid[0]),
        .dst       (div_data[0])
    );

    genvar k;
    generate
        for (k = 0; k < UV_BITS; k++)
        begin : g_cell
            cfs_div_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (cell_en[k]),
                .src_valid (div_valid[k]),
                .src       (div_data[k]),
                .dst_valid (div_valid[k+1]),
                .dst       (div_data[k+1])
            );
            // A stage advances when it is empty or the stage after it advances.
            if (k == UV_BITS - 1)
            begin : g_tail
                assign cell_en[k] = !div_valid[k+1] || res_ready;
            end
            else
            begin : g_mid
                assign cell_en[k] = !div_valid[k+1] || cell_en[k+1];
            end
        end
    endgenerate

    assign en_b      = !div_valid[0] || cell_en[0];
    assign en_a      = !sel_valid || en_b;
    assign dir_ready = en_a;

    assign last      = div_data[UV_BITS];
    assign res_valid = div_valid[UV_BITS];

    always_comb
    begin
        res.face           = last.face;
        res.zero_direction = last.zero;
        priority if (last.zero)
        begin
            res.tex_u = '0;
            res.tex_v = '0;
        end
        else
        begin
            res.tex_u = last.sat_u ? {UV_BITS{1'b1}} : last.quo_u;
            res.tex_v = last.sat_v ? {UV_BITS{1'b1}} : last.quo_v;
        end
    end

    // Input stalls only when every stage is full and the result is held.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !dir_ready |-> (res_valid && !res_ready && (&div_valid) && sel_valid))
        else $error("input stalled with a bubble in the pipeline");

    // Divider setup: nonzero divisor, numerator within [0, divisor].
    a_div_setup: assert property (@(posedge clk) disable iff (!rst_n)
        (div_valid[0] && !div_data[0].zero) |->
        ((div_data[0].den != '0) && (div_data[0].rem_u <= div_data[0].den)
         && (div_data[0].rem_v <= div_data[0].den)))
        else $error("bad divider setup");

    // A zero vector always lands on the front face.
    a_zero_face: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.zero_direction) |-> (res.face == FACE_FRONT))
        else $error("zero vector not on front face");

    // A held result keeps its face while waiting.
    a_hold_face: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res.face)))
        else $error("stalled result changed");

endmodule
